// ===== rtl/mafs_pkg.sv =====
package mafs_pkg;

    // Header recognition and DAB grading masks
    localparam logic [15:0] SYNC_MASK = 16'he0ff;
    localparam logic [31:0] DAB_MASK  = 32'h0f0ffcff;
    localparam logic [31:0] DAB_MPEG1 = 32'h0004fcff;
    localparam logic [31:0] DAB_MPEG2 = 32'h0004f4ff;

    // Search limit after reset
    localparam logic [15:0] SEARCH_LIMIT_RESET = 16'd1200;

    // Sampling rates that DAB allows
    localparam logic [15:0] FS_DAB_HIGH = 16'd48000;
    localparam logic [15:0] FS_DAB_LOW  = 16'd24000;

    // Frame length scale factors for layers II/III and layer I
    localparam logic [17:0] SCALE_L23 = 18'd144000;
    localparam logic [17:0] SCALE_L1  = 18'd12000;

    // Width of the divider operands
    localparam int DIVIDEND_W = 27;
    localparam int DIVISOR_W  = 16;
    localparam int QUOT_W     = 12;

    // Event codes of a result item
    localparam logic [1:0] EV_FRAME   = 2'd0;
    localparam logic [1:0] EV_NO_SYNC = 2'd1;
    localparam logic [1:0] EV_INVALID = 2'd2;

    // DAB conformance codes
    localparam logic [2:0] DAB_OK        = 3'd0;
    localparam logic [2:0] DAB_FREQUENCY = 3'd1;
    localparam logic [2:0] DAB_PADDING   = 3'd2;
    localparam logic [2:0] DAB_COPYRIGHT = 3'd3;
    localparam logic [2:0] DAB_ORIGINAL  = 3'd4;
    localparam logic [2:0] DAB_EMPHASIS  = 3'd5;
    localparam logic [2:0] DAB_OTHER     = 3'd6;

    // Version field codes
    localparam logic [1:0] VER_MPEG25   = 2'd0;
    localparam logic [1:0] VER_RESERVED = 2'd1;
    localparam logic [1:0] VER_MPEG2    = 2'd2;
    localparam logic [1:0] VER_MPEG1    = 2'd3;

    // Layer field codes
    localparam logic [1:0] LAYER_RESERVED = 2'd0;
    localparam logic [1:0] LAYER_III      = 2'd1;
    localparam logic [1:0] LAYER_II       = 2'd2;
    localparam logic [1:0] LAYER_I        = 2'd3;

    // Parse phases
    localparam logic PHASE_HUNT    = 1'b0;
    localparam logic PHASE_PAYLOAD = 1'b1;

    // Bitrate tables in kbit/s; zero marks free format or reserved
    localparam logic [8:0] BR_LSF_L23 [16] = '{
        9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
        9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0
    };
    localparam logic [8:0] BR_LSF_L1 [16] = '{
        9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
        9'd128, 9'd144, 9'd160, 9'd176, 9'd192, 9'd224, 9'd256, 9'd0
    };
    localparam logic [8:0] BR_V1_L3 [16] = '{
        9'd0, 9'd32, 9'd40, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96,
        9'd112, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd0
    };
    localparam logic [8:0] BR_V1_L2 [16] = '{
        9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
        9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd384, 9'd0
    };
    localparam logic [8:0] BR_V1_L1 [16] = '{
        9'd0, 9'd32, 9'd64, 9'd96, 9'd128, 9'd160, 9'd192, 9'd224,
        9'd256, 9'd288, 9'd320, 9'd352, 9'd384, 9'd416, 9'd448, 9'd0
    };

    // Request to the frame length divider
    typedef struct packed {
        logic                  start;
        logic [DIVIDEND_W-1:0] dividend;
        logic [DIVISOR_W-1:0]  divisor;
    } div_req_t;

    // Answer from the frame length divider
    typedef struct packed {
        logic              busy;
        logic              done;
        logic [QUOT_W-1:0] quotient;
    } div_res_t;

    // Bitrate by version, layer and bitrate index
    function automatic logic [8:0] rate_lookup(input logic [1:0] ver,
                                               input logic [1:0] layer,
                                               input logic [3:0] bidx);
        logic [8:0] r;
        begin
            r = 9'd0;
            unique case (ver) inside
                VER_MPEG25, VER_MPEG2:
                begin
                    if (layer == LAYER_I)
                        r = BR_LSF_L1[bidx];
                    else if (layer != LAYER_RESERVED)
                        r = BR_LSF_L23[bidx];
                end
                VER_MPEG1:
                begin
                    unique case (layer)
                        LAYER_III: r = BR_V1_L3[bidx];
                        LAYER_II:  r = BR_V1_L2[bidx];
                        LAYER_I:   r = BR_V1_L1[bidx];
                        default:   r = 9'd0;
                    endcase
                end
                default: r = 9'd0;
            endcase
            return r;
        end
    endfunction

    // Sampling rate by version and sampling index
    function automatic logic [15:0] fs_lookup(input logic [1:0] ver,
                                              input logic [1:0] sidx);
        logic [15:0] f;
        begin
            f = 16'd0;
            unique case ({ver, sidx})
                4'b00_00: f = 16'd11025;
                4'b00_01: f = 16'd12000;
                4'b00_10: f = 16'd8000;
                4'b10_00: f = 16'd22050;
                4'b10_01: f = 16'd24000;
                4'b10_10: f = 16'd16000;
                4'b11_00: f = 16'd44100;
                4'b11_01: f = 16'd48000;
                4'b11_10: f = 16'd32000;
                default:  f = 16'd0;
            endcase
            return f;
        end
    endfunction

    // DAB conformance grade of a header window
    function automatic logic [2:0] dab_grade(input logic [31:0] w,
                                             input logic [15:0] fs);
        logic [2:0] g;
        begin
            if ((w & DAB_MASK) == DAB_MPEG1 || (w & DAB_MASK) == DAB_MPEG2)
                g = DAB_OK;
            else if (fs != FS_DAB_HIGH && fs != FS_DAB_LOW)
                g = DAB_FREQUENCY;
            else if (w[17])
                g = DAB_PADDING;
            else if (w[27])
                g = DAB_COPYRIGHT;
            else if (w[26])
                g = DAB_ORIGINAL;
            else if (w[25:24] != 2'd0)
                g = DAB_EMPHASIS;
            else
                g = DAB_OTHER;
            return g;
        end
    endfunction

endpackage

// ===== rtl/mafs_in_if.sv =====
// Byte stream channel into the frame synchroniser.
interface mafs_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] stream_byte;

    modport source (output valid, output stream_byte, input ready);
    modport sink (input valid, input stream_byte, output ready);
endinterface

// ===== rtl/mafs_out_if.sv =====
// Result channel out of the frame synchroniser.
interface mafs_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  data_byte;
    logic [1:0]  event_kind;
    logic        frame_start;
    logic        frame_last;
    logic        run_last;
    logic [11:0] frame_length;
    logic [8:0]  bitrate_kbps;
    logic [15:0] sample_rate_hz;
    logic [2:0]  dab_status;

    modport source (output valid, output data_byte, output event_kind,
                    output frame_start, output frame_last, output run_last,
                    output frame_length, output bitrate_kbps,
                    output sample_rate_hz, output dab_status, input ready);
    modport sink (input valid, input data_byte, input event_kind,
                  input frame_start, input frame_last, input run_last,
                  input frame_length, input bitrate_kbps,
                  input sample_rate_hz, input dab_status, output ready);
endinterface

// ===== rtl/mafs_div.sv =====
// Restoring divider, one quotient bit a cycle. The caller guarantees that
// the quotient fits in QUOT_W bits, so the upper dividend bits start out as
// a partial remainder below the divisor.
module mafs_div
(
    input  logic               clk,
    input  logic               rst_n,
    input  mafs_pkg::div_req_t req,
    output mafs_pkg::div_res_t res
);
    import mafs_pkg::*;

    localparam int CNT_W = $clog2(QUOT_W);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(QUOT_W - 1);

    logic                 busy_reg;
    logic                 done_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [DIVISOR_W-1:0] rem_reg;
    logic [DIVISOR_W-1:0] rem_next;
    logic [QUOT_W-1:0]    dq_reg;
    logic [QUOT_W-1:0]    dq_next;
    logic [DIVISOR_W-1:0] divisor_reg;
    logic [DIVISOR_W:0]   trial;
    logic                 fits;

    // One compare and subtract step
    always_comb
    begin
        trial    = {rem_reg, dq_reg[QUOT_W-1]};
        fits     = trial >= {1'b0, divisor_reg};
        rem_next = fits ? DIVISOR_W'(trial - {1'b0, divisor_reg})
                        : trial[DIVISOR_W-1:0];
        dq_next  = {dq_reg[QUOT_W-2:0], fits};
    end

    // Step counter and completion flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == LAST_STEP)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Remainder and quotient shift register
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg     <= DIVISOR_W'(req.dividend[DIVIDEND_W-1:QUOT_W]);
            dq_reg      <= req.dividend[QUOT_W-1:0];
            divisor_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            dq_reg  <= dq_next;
        end
    end

    assign res.busy     = busy_reg;
    assign res.done     = done_reg;
    assign res.quotient = dq_reg;

endmodule

// ===== rtl/mpeg_audio_frame_sync.sv =====
// A payload byte or a byte that ends a hunt waits in the pending register until the
// output register takes it; a byte that gives no result leaves the input ready.
// A valid header passes the multiply, start, divider and length steps, then its
// four header items leave one a cycle while the output is taken.
// Asynchronous active-low reset clears the hunt state and sets the limit to 1200.
module mpeg_audio_frame_sync
(
    input  logic        clk,
    input  logic        rst_n,
    mafs_in_if.sink     stream,
    mafs_out_if.source  result,
    input  logic        cfg_wen,
    input  logic [15:0] cfg_wdata
);
    import mafs_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_ONE   = 3'd1;
    localparam logic [2:0] ST_MUL   = 3'd2;
    localparam logic [2:0] ST_START = 3'd3;
    localparam logic [2:0] ST_DIV   = 3'd4;
    localparam logic [2:0] ST_HDR   = 3'd5;

    // Control state
    logic [2:0]  state_reg, state_next;
    logic [31:0] window_reg, window_next;
    logic [2:0]  fill_reg, fill_next;
    logic        phase_reg, phase_next;
    logic [15:0] count_reg, count_next;
    logic [11:0] left_reg, left_next;
    logic [15:0] limit_reg;
    logic [1:0]  idx_reg, idx_next;
    logic        out_valid_reg, out_valid_next;

    // Payload registers
    logic [7:0]  pend_byte_reg, pend_byte_next;
    logic [1:0]  pend_kind_reg, pend_kind_next;
    logic        pend_last_reg, pend_last_next;
    logic [31:0] hdr_reg, hdr_next;
    logic [8:0]  br_reg, br_next;
    logic [15:0] fs_reg, fs_next;
    logic [2:0]  dab_reg, dab_next;
    logic [11:0] len_reg, len_next;
    logic [DIVIDEND_W-1:0] dividend_reg, dividend_next;

    // Output register
    logic [7:0]  o_byte_reg, o_byte_next;
    logic [1:0]  o_kind_reg, o_kind_next;
    logic        o_start_reg, o_start_next;
    logic        o_last_reg, o_last_next;
    logic        o_run_reg, o_run_next;
    logic [11:0] o_len_reg, o_len_next;
    logic [8:0]  o_br_reg, o_br_next;
    logic [15:0] o_fs_reg, o_fs_next;
    logic [2:0]  o_dab_reg, o_dab_next;

    // Working signals
    logic        accept;
    logic        slot_free;
    logic        out_load;
    logic [31:0] win_shift;
    logic        sync_hit;
    logic [8:0]  lk_br;
    logic [15:0] lk_fs;
    logic        test;
    logic [11:0] left_dec;
    logic        layer1;
    logic [17:0] scale;
    logic [12:0] qp;
    logic [11:0] len_calc;
    logic [7:0]  hdr_byte;

    div_req_t div_req;
    div_res_t div_res;

    mafs_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .res   (div_res)
    );

    assign accept    = stream.valid && stream.ready;
    assign slot_free = !out_valid_reg || result.ready;
    assign stream.ready = (state_reg == ST_IDLE);

    // Window shift and header table lookup
    assign win_shift = {stream.stream_byte, window_reg[31:8]};
    assign sync_hit  = (win_shift[15:0] & SYNC_MASK) == SYNC_MASK;
    assign lk_br     = rate_lookup(win_shift[12:11], win_shift[10:9], win_shift[23:20]);
    assign lk_fs     = fs_lookup(win_shift[12:11], win_shift[19:18]);

    // Stored header fields
    assign layer1   = hdr_reg[10:9] == LAYER_I;
    assign scale    = layer1 ? SCALE_L1 : SCALE_L23;
    assign qp       = {1'b0, div_res.quotient} + 13'(hdr_reg[17]);
    assign len_calc = layer1 ? {qp[9:0], 2'b00} : qp[11:0];
    assign hdr_byte = 8'(hdr_reg >> {idx_reg, 3'b000});

    assign div_req.start    = (state_reg == ST_START);
    assign div_req.dividend = dividend_reg;
    assign div_req.divisor  = fs_reg;

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        window_next    = window_reg;
        fill_next      = fill_reg;
        phase_next     = phase_reg;
        count_next     = count_reg;
        left_next      = left_reg;
        idx_next       = idx_reg;
        pend_byte_next = pend_byte_reg;
        pend_kind_next = pend_kind_reg;
        pend_last_next = pend_last_reg;
        hdr_next       = hdr_reg;
        br_next        = br_reg;
        fs_next        = fs_reg;
        dab_next       = dab_reg;
        len_next       = len_reg;
        dividend_next  = dividend_reg;
        out_load       = 1'b0;
        o_byte_next    = o_byte_reg;
        o_kind_next    = o_kind_reg;
        o_start_next   = o_start_reg;
        o_last_next    = o_last_reg;
        o_run_next     = o_run_reg;
        o_len_next     = o_len_reg;
        o_br_next      = o_br_reg;
        o_fs_next      = o_fs_reg;
        o_dab_next     = o_dab_reg;
        test           = 1'b0;
        left_dec       = (left_reg != 12'd0) ? left_reg - 12'd1 : left_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (phase_reg == PHASE_PAYLOAD)
                    begin
                        // Payload byte passes straight through
                        left_next      = left_dec;
                        pend_byte_next = stream.stream_byte;
                        pend_kind_next = EV_FRAME;
                        pend_last_next = (left_dec == 12'd0);
                        state_next     = ST_ONE;
                        if (left_dec == 12'd0)
                        begin
                            phase_next  = PHASE_HUNT;
                            window_next = '0;
                            fill_next   = '0;
                            count_next  = '0;
                        end
                    end
                    else
                    begin
                        window_next = win_shift;
                        if (fill_reg < 3'd4)
                        begin
                            fill_next = fill_reg + 3'd1;
                            test      = (fill_reg == 3'd3);
                        end
                        else if (count_reg >= limit_reg)
                        begin
                            // Hunt ran out of shifts
                            window_next    = '0;
                            fill_next      = '0;
                            count_next     = '0;
                            pend_byte_next = 8'd0;
                            pend_kind_next = EV_NO_SYNC;
                            pend_last_next = 1'b0;
                            state_next     = ST_ONE;
                        end
                        else
                        begin
                            count_next = count_reg + 16'd1;
                            test       = 1'b1;
                        end

                        if (test && sync_hit)
                        begin
                            window_next = '0;
                            fill_next   = '0;
                            count_next  = '0;
                            if (lk_br == 9'd0 || lk_fs == 16'd0)
                            begin
                                // Reserved or free-format header
                                pend_byte_next = 8'd0;
                                pend_kind_next = EV_INVALID;
                                pend_last_next = 1'b0;
                                state_next     = ST_ONE;
                            end
                            else
                            begin
                                hdr_next   = win_shift;
                                br_next    = lk_br;
                                fs_next    = lk_fs;
                                phase_next = PHASE_PAYLOAD;
                                state_next = ST_MUL;
                            end
                        end
                    end
                end
            end
            ST_ONE:
            begin
                if (slot_free)
                begin
                    out_load     = 1'b1;
                    o_byte_next  = pend_byte_reg;
                    o_kind_next  = pend_kind_reg;
                    o_start_next = 1'b0;
                    o_last_next  = pend_last_reg;
                    o_run_next   = 1'b1;
                    o_len_next   = '0;
                    o_br_next    = '0;
                    o_fs_next    = '0;
                    o_dab_next   = '0;
                    state_next   = ST_IDLE;
                end
            end
            ST_MUL:
            begin
                // Scaled bitrate for the length division, and the DAB grade
                dividend_next = DIVIDEND_W'(27'(scale) * 27'(br_reg));
                dab_next      = dab_grade(hdr_reg, fs_reg);
                state_next    = ST_START;
            end
            ST_START:
            begin
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_res.done)
                begin
                    len_next   = len_calc;
                    left_next  = len_calc - 12'd4;
                    idx_next   = 2'd0;
                    state_next = ST_HDR;
                end
            end
            ST_HDR:
            begin
                if (slot_free)
                begin
                    out_load     = 1'b1;
                    o_byte_next  = hdr_byte;
                    o_kind_next  = EV_FRAME;
                    o_start_next = (idx_reg == 2'd0);
                    o_last_next  = 1'b0;
                    o_run_next   = (idx_reg == 2'd3);
                    o_len_next   = (idx_reg == 2'd0) ? len_reg : 12'd0;
                    o_br_next    = (idx_reg == 2'd0) ? br_reg : 9'd0;
                    o_fs_next    = (idx_reg == 2'd0) ? fs_reg : 16'd0;
                    o_dab_next   = (idx_reg == 2'd0) ? dab_reg : 3'd0;
                    idx_next     = idx_reg + 2'd1;
                    if (idx_reg == 2'd3)
                        state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output valid follows loads and takes
    always_comb
    begin
        if (out_load)
            out_valid_next = 1'b1;
        else if (result.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            window_reg    <= '0;
            fill_reg      <= '0;
            phase_reg     <= PHASE_HUNT;
            count_reg     <= '0;
            left_reg      <= '0;
            limit_reg     <= SEARCH_LIMIT_RESET;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            window_reg    <= window_next;
            fill_reg      <= fill_next;
            phase_reg     <= phase_next;
            count_reg     <= count_next;
            left_reg      <= left_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wen)
                limit_reg <= cfg_wdata;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        pend_byte_reg <= pend_byte_next;
        pend_kind_reg <= pend_kind_next;
        pend_last_reg <= pend_last_next;
        hdr_reg       <= hdr_next;
        br_reg        <= br_next;
        fs_reg        <= fs_next;
        dab_reg       <= dab_next;
        len_reg       <= len_next;
        dividend_reg  <= dividend_next;
        o_byte_reg    <= o_byte_next;
        o_kind_reg    <= o_kind_next;
        o_start_reg   <= o_start_next;
        o_last_reg    <= o_last_next;
        o_run_reg     <= o_run_next;
        o_len_reg     <= o_len_next;
        o_br_reg      <= o_br_next;
        o_fs_reg      <= o_fs_next;
        o_dab_reg     <= o_dab_next;
    end

    assign result.valid          = out_valid_reg;
    assign result.data_byte      = o_byte_reg;
    assign result.event_kind     = o_kind_reg;
    assign result.frame_start    = o_start_reg;
    assign result.frame_last     = o_last_reg;
    assign result.run_last       = o_run_reg;
    assign result.frame_length   = o_len_reg;
    assign result.bitrate_kbps   = o_br_reg;
    assign result.sample_rate_hz = o_fs_reg;
    assign result.dab_status     = o_dab_reg;

endmodule
